[rtl/crtclt_pkg.sv]
// Shared types, constants and helpers of the CRTC line timing block.
package crtclt_pkg;

  localparam int VisibleLinesDefault = 272;

  // Bus decode.
  localparam logic [15:0] ADDR_DECODE_MASK = 16'hBF00;
  localparam logic [15:0] ADDR_SELECT      = 16'hBC00;
  localparam logic [15:0] ADDR_DATA        = 16'hBD00;

  // Word kinds.
  localparam logic FUNC_BUS_WRITE = 1'b0;
  localparam logic FUNC_TICK      = 1'b1;

  localparam int NumRegs = 16;

  // Frame timing constants.
  localparam logic [8:0] FirstDrawLine = 9'd32;
  localparam logic [8:0] LastFrameLine = 9'd312;
  localparam logic [5:0] IrqPeriod     = 6'd52;
  localparam logic [4:0] VsyncLines    = 5'd16;
  localparam logic [7:0] HCenter       = 8'd50;
  localparam logic [6:0] HEndMax       = 7'd96;
  localparam logic [6:0] HStartReset   = 7'd8;

  typedef struct packed {
    logic        func;
    logic [15:0] bus_addr;
    logic [7:0]  bus_data;
  } crtclt_in_t;

  typedef struct packed {
    logic [8:0]  line_number;
    logic        vsync_active;
    logic        irq_raise;
    logic        draw_valid;
    logic [8:0]  draw_row;
    logic        border_line;
    logic [16:0] video_addr;
    logic [15:0] raster_addr;
    logic        resync_flag;
    logic [6:0]  x_start;
    logic [6:0]  x_end;
  } crtclt_out_t;

  // Register values that the line timing logic needs.
  typedef struct packed {
    logic [7:0] r1;
    logic [7:0] r4;
    logic [7:0] r6;
    logic [7:0] r7;
    logic [7:0] r9;
    logic [7:0] r12;
    logic [7:0] r13;
  } crtclt_geom_t;

  // Per-tick status from the timing counters.
  typedef struct packed {
    logic [8:0]  line_number;
    logic        vsync_active;
    logic        irq_raise;
    logic        draw_valid;
    logic [8:0]  draw_row;
    logic        border_line;
    logic [16:0] video_addr;
    logic [15:0] raster_addr;
    logic        resync_flag;
  } crtclt_timing_t;

  // Bits that each register actually implements.
  function automatic logic [7:0] write_mask(input logic [3:0] idx);
    logic [7:0] m;
    case (idx)
      4'd4, 4'd6, 4'd7, 4'd10: m = 8'h7F;
      4'd5, 4'd9, 4'd11:       m = 8'h1F;
      4'd8:                    m = 8'hF3;
      4'd12, 4'd14:            m = 8'h3F;
      default:                 m = 8'hFF;
    endcase
    return m;
  endfunction

endpackage

[rtl/crtc_line_timing.sv]
// Top level of the CRTC line timing block: handshake and result register.
// Each input word is a bus write or one scanline tick and yields exactly one
// result word. The block takes one word per clock: the state counters and
// registers update at the edge that accepts a word, and the result is held in
// a single output register, so a word is accepted whenever that register is
// empty or being read in the same cycle. The result becomes valid in the cycle
// after the word is accepted. The result shows the line counter, sync and
// interrupt state, the draw row with its video and raster addresses, and the
// horizontal window after the word. There is no clearing pass after reset.
module crtc_line_timing #(
  parameter int VISIBLE_LINES = crtclt_pkg::VisibleLinesDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  crtclt_pkg::crtclt_in_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output crtclt_pkg::crtclt_out_t out_data
);

  logic                       accept;
  logic                       is_tick;
  crtclt_pkg::crtclt_geom_t   geom;
  crtclt_pkg::crtclt_timing_t status;
  logic [6:0]                 hstart_next;
  logic [6:0]                 hend_next;
  crtclt_pkg::crtclt_out_t    result;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_tick  = in_data.func == crtclt_pkg::FUNC_TICK;

  crtclt_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .step        (accept && !is_tick),
    .bus_addr    (in_data.bus_addr),
    .bus_data    (in_data.bus_data),
    .geom        (geom),
    .hstart_next (hstart_next),
    .hend_next   (hend_next)
  );

  crtclt_timing #(
    .VISIBLE_LINES (VISIBLE_LINES)
  ) u_timing (
    .clk    (clk),
    .rst    (rst),
    .tick   (accept && is_tick),
    .geom   (geom),
    .status (status)
  );

  always_comb begin
    result.line_number  = status.line_number;
    result.vsync_active = status.vsync_active;
    result.irq_raise    = status.irq_raise;
    result.draw_valid   = status.draw_valid;
    result.draw_row     = status.draw_row;
    result.border_line  = status.border_line;
    result.video_addr   = status.video_addr;
    result.raster_addr  = status.raster_addr;
    result.resync_flag  = status.resync_flag;
    result.x_start      = hstart_next;
    result.x_end        = hend_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

[rtl/crtclt_regs.sv]
// Register file, register select and horizontal window calculation.
module crtclt_regs (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [15:0]             bus_addr,
  input  logic [7:0]              bus_data,
  output crtclt_pkg::crtclt_geom_t geom,
  output logic [6:0]              hstart_next,
  output logic [6:0]              hend_next
);

  logic [7:0] regs [crtclt_pkg::NumRegs];
  logic [7:0] regs_next [crtclt_pkg::NumRegs];
  logic [4:0] reg_select;
  logic [4:0] reg_select_next;
  logic [6:0] hstart;
  logic [6:0] hend;
  logic [15:0] addr_dec;
  logic [6:0] s_calc;
  logic [9:0] e_calc;

  assign addr_dec = bus_addr & crtclt_pkg::ADDR_DECODE_MASK;

  always_comb begin
    regs_next = regs;
    reg_select_next = reg_select;
    if (step) begin
      if (addr_dec == crtclt_pkg::ADDR_SELECT) begin
        reg_select_next = bus_data[4:0];
      end else if (addr_dec == crtclt_pkg::ADDR_DATA && !reg_select[4]) begin
        regs_next[reg_select[3:0]] = bus_data & crtclt_pkg::write_mask(reg_select[3:0]);
      end
    end
  end

  // The window is recomputed on every bus write from the updated registers.
  always_comb begin
    s_calc = (regs_next[2] < crtclt_pkg::HCenter)
           ? {crtclt_pkg::HCenter[5:0] - regs_next[2][5:0], 1'b0} : 7'd0;
    e_calc = {3'd0, s_calc} + {1'b0, regs_next[1], 1'b0};
    if (step) begin
      hstart_next = s_calc;
      hend_next   = (e_calc > {3'd0, crtclt_pkg::HEndMax}) ? crtclt_pkg::HEndMax : e_calc[6:0];
    end else begin
      hstart_next = hstart;
      hend_next   = hend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < crtclt_pkg::NumRegs; i++) begin
        regs[i] <= (i == 0) ? 8'h00 : 8'hFF;
      end
      reg_select <= 5'd0;
      hstart     <= crtclt_pkg::HStartReset;
      hend       <= 7'd0;
    end else begin
      regs       <= regs_next;
      reg_select <= reg_select_next;
      hstart     <= hstart_next;
      hend       <= hend_next;
    end
  end

  assign geom.r1  = regs[1];
  assign geom.r4  = regs[4];
  assign geom.r6  = regs[6];
  assign geom.r7  = regs[7];
  assign geom.r9  = regs[9];
  assign geom.r12 = regs[12];
  assign geom.r13 = regs[13];

endmodule

[rtl/crtclt_timing.sv]
// Raster, character row, address, vertical sync and interrupt counters.
module crtclt_timing #(
  parameter int VISIBLE_LINES = crtclt_pkg::VisibleLinesDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      tick,
  input  crtclt_pkg::crtclt_geom_t   geom,
  output crtclt_pkg::crtclt_timing_t status
);

  localparam logic [9:0] DrawEnd = 10'(VISIBLE_LINES + 32);

  logic [4:0]  vbl_length, vbl_length_next;
  logic [6:0]  char_row, char_row_next;
  logic [4:0]  raster_row, raster_row_next;
  logic [8:0]  line_count, line_count_next;
  logic [15:0] mem_addr, mem_addr_next;
  logic [1:0]  sync_delay, sync_delay_next;
  logic [5:0]  irq_line_count, irq_line_count_next;
  logic        vsync_level, vsync_level_next;
  logic        resync_pending, resync_pending_next;

  always_comb begin
    vbl_length_next     = vbl_length;
    char_row_next       = char_row;
    raster_row_next     = raster_row;
    line_count_next     = line_count;
    mem_addr_next       = mem_addr;
    sync_delay_next     = sync_delay;
    irq_line_count_next = irq_line_count;
    vsync_level_next    = vsync_level;
    resync_pending_next = resync_pending;
    status.irq_raise    = 1'b0;
    status.draw_valid   = 1'b0;
    status.draw_row     = 9'd0;
    status.border_line  = 1'b0;
    status.video_addr   = 17'd0;
    status.raster_addr  = 16'd0;
    if (tick) begin
      // Sync length counts down and sticks at zero; sync drops on the last step.
      if (vbl_length != 5'd0) begin
        vbl_length_next = vbl_length - 5'd1;
        if (vbl_length == 5'd1) begin
          vsync_level_next = 1'b0;
        end
      end
      line_count_next = line_count + 9'd1;

      if ({3'd0, raster_row} == geom.r9) begin
        raster_row_next = 5'd0;
        char_row_next   = char_row + 7'd1;
        mem_addr_next   = mem_addr + {8'd0, geom.r1};
      end else begin
        raster_row_next = raster_row + 5'd1;
      end

      if ({2'd0, char_row_next} == {1'b0, geom.r4} + 9'd1) begin
        raster_row_next = 5'd0;
        char_row_next   = 7'd0;
        mem_addr_next   = {geom.r12, geom.r13};
      end

      if ({1'b0, char_row_next} == geom.r7 && raster_row_next == 5'd0) begin
        line_count_next     = 9'd0;
        vbl_length_next     = crtclt_pkg::VsyncLines;
        sync_delay_next     = 2'd2;
        vsync_level_next    = 1'b1;
        resync_pending_next = 1'b1;
      end else if (line_count_next >= crtclt_pkg::FirstDrawLine
                   && {1'b0, line_count_next} < DrawEnd) begin
        status.draw_valid = 1'b1;
        status.draw_row   = line_count_next - crtclt_pkg::FirstDrawLine;
        if ({1'b0, char_row_next} < geom.r6) begin
          status.video_addr = {mem_addr_next, 1'b0};
        end else begin
          status.border_line = 1'b1;
        end
        status.raster_addr = {raster_row_next, 11'd0} | {mem_addr_next[13:12], 14'd0};
      end else if (line_count_next > crtclt_pkg::LastFrameLine) begin
        line_count_next     = 9'd0;
        resync_pending_next = 1'b0;
      end

      // After vsync the interrupt counter resyncs on the following line.
      irq_line_count_next = irq_line_count + 6'd1;
      if (sync_delay_next == 2'd0) begin
        if (irq_line_count_next == crtclt_pkg::IrqPeriod) begin
          irq_line_count_next = 6'd0;
          status.irq_raise    = 1'b1;
        end
      end else begin
        sync_delay_next = sync_delay_next - 2'd1;
        if (sync_delay_next == 2'd0) begin
          status.irq_raise    = irq_line_count_next[5];
          irq_line_count_next = 6'd0;
        end
      end
    end
    status.line_number  = line_count_next;
    status.vsync_active = vsync_level_next;
    status.resync_flag  = resync_pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbl_length     <= crtclt_pkg::VsyncLines;
      char_row       <= 7'd0;
      raster_row     <= 5'd0;
      line_count     <= 9'd0;
      mem_addr       <= 16'd0;
      sync_delay     <= 2'd0;
      irq_line_count <= 6'd0;
      vsync_level    <= 1'b0;
      resync_pending <= 1'b0;
    end else begin
      vbl_length     <= vbl_length_next;
      char_row       <= char_row_next;
      raster_row     <= raster_row_next;
      line_count     <= line_count_next;
      mem_addr       <= mem_addr_next;
      sync_delay     <= sync_delay_next;
      irq_line_count <= irq_line_count_next;
      vsync_level    <= vsync_level_next;
      resync_pending <= resync_pending_next;
    end
  end

endmodule

[verif/crtc_line_timing_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the CRTC line timing block: predicts every result word and compares it.
module crtc_line_timing_checker #(
  parameter int VISIBLE_LINES = crtclt_pkg::VisibleLinesDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  crtclt_pkg::crtclt_in_t  in_data,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  crtclt_pkg::crtclt_out_t out_data,
  output int                      mismatches,
  output int                      outstanding
);

  localparam int RegHDisp     = 1;
  localparam int RegHSyncPos  = 2;
  localparam int RegVTotal    = 4;
  localparam int RegVDisp     = 6;
  localparam int RegVSyncPos  = 7;
  localparam int RegMaxRaster = 9;
  localparam int RegStartHi   = 12;
  localparam int RegStartLo   = 13;

  // Implemented bits of registers 0 to 15, register 0 leftmost.
  localparam logic [0:crtclt_pkg::NumRegs-1][7:0] RegBits = {
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h1F, 8'h7F, 8'h7F,
    8'hF3, 8'h1F, 8'h7F, 8'h1F, 8'h3F, 8'hFF, 8'h3F, 8'hFF
  };

  logic [7:0]  regs [crtclt_pkg::NumRegs];
  logic [4:0]  sel;
  logic [6:0]  hstart;
  logic [6:0]  hend;
  logic [4:0]  vbl;
  logic [6:0]  char_row;
  logic [4:0]  raster_row;
  logic [8:0]  line_cnt;
  logic [15:0] maddr;
  logic [1:0]  sync_dly;
  logic [5:0]  irq_cnt;
  logic        vsync;
  logic        resync;

  crtclt_pkg::crtclt_out_t due_status [$];
  int          fail_count = 0;

  function automatic void reset_timing();
    foreach (regs[i]) regs[i] = 8'hFF;
    regs[0] = 8'h00;
    sel = '0;
    hstart = crtclt_pkg::HStartReset;
    hend = '0;
    vbl = crtclt_pkg::VsyncLines;
    char_row = '0;
    raster_row = '0;
    line_cnt = '0;
    maddr = '0;
    sync_dly = '0;
    irq_cnt = '0;
    vsync = 1'b0;
    resync = 1'b0;
  endfunction

  // Applies one word to the timing state and returns the status it leaves behind.
  function automatic crtclt_pkg::crtclt_out_t apply_word(crtclt_pkg::crtclt_in_t w);
    crtclt_pkg::crtclt_out_t r;
    logic [15:0] a;
    int          s;
    int          e;
    r = '0;
    if (w.func == crtclt_pkg::FUNC_BUS_WRITE) begin
      a = w.bus_addr & crtclt_pkg::ADDR_DECODE_MASK;
      if (a == crtclt_pkg::ADDR_SELECT) begin
        sel = w.bus_data[4:0];
      end else if (a == crtclt_pkg::ADDR_DATA && int'(sel) < crtclt_pkg::NumRegs) begin
        regs[sel[3:0]] = w.bus_data & RegBits[sel[3:0]];
      end
      s = (regs[RegHSyncPos] < crtclt_pkg::HCenter)
        ? 2 * (int'(crtclt_pkg::HCenter) - int'(regs[RegHSyncPos])) : 0;
      e = s + 2 * int'(regs[RegHDisp]);
      hstart = s[6:0];
      hend = (e > int'(crtclt_pkg::HEndMax)) ? crtclt_pkg::HEndMax : e[6:0];
    end else begin
      if (vbl != 0) begin
        vbl = vbl - 5'd1;
        if (vbl == 0) vsync = 1'b0;
      end
      line_cnt = line_cnt + 9'd1;

      if ({3'b000, raster_row} == regs[RegMaxRaster]) begin
        raster_row = '0;
        char_row = char_row + 7'd1;
        maddr = maddr + {8'h00, regs[RegHDisp]};
      end else begin
        raster_row = raster_row + 5'd1;
      end

      // Vertical total is inclusive, so the reload happens one row past it.
      if (int'(char_row) == int'(regs[RegVTotal]) + 1) begin
        raster_row = '0;
        char_row = '0;
        maddr = {regs[RegStartHi], regs[RegStartLo]};
      end

      if ({1'b0, char_row} == regs[RegVSyncPos] && raster_row == 0) begin
        line_cnt = '0;
        vbl = crtclt_pkg::VsyncLines;
        sync_dly = 2'd2;
        vsync = 1'b1;
        resync = 1'b1;
      end else if (line_cnt >= crtclt_pkg::FirstDrawLine &&
                   int'(line_cnt - crtclt_pkg::FirstDrawLine) < VISIBLE_LINES) begin
        r.draw_valid = 1'b1;
        r.draw_row = line_cnt - crtclt_pkg::FirstDrawLine;
        if ({1'b0, char_row} < regs[RegVDisp]) r.video_addr = {maddr, 1'b0};
        else r.border_line = 1'b1;
        r.raster_addr = {raster_row, 11'b0} | {maddr[13:12], 14'b0};
      end else if (line_cnt > crtclt_pkg::LastFrameLine) begin
        line_cnt = '0;
        resync = 1'b0;
      end

      irq_cnt = irq_cnt + 6'd1;
      if (sync_dly == 0) begin
        if (irq_cnt == crtclt_pkg::IrqPeriod) begin
          irq_cnt = '0;
          r.irq_raise = 1'b1;
        end
      end else begin
        // On the line after vsync the interrupt counter is realigned.
        sync_dly = sync_dly - 2'd1;
        if (sync_dly == 0) begin
          r.irq_raise = irq_cnt[5];
          irq_cnt = '0;
        end
      end
    end
    r.line_number = line_cnt;
    r.vsync_active = vsync;
    r.resync_flag = resync;
    r.x_start = hstart;
    r.x_end = hend;
    return r;
  endfunction

  function automatic string field_diffs(crtclt_pkg::crtclt_out_t want,
                                        crtclt_pkg::crtclt_out_t got);
    string d;
    d = "";
    if (want.line_number !== got.line_number)
      d = {d, $sformatf(" line_number %0d/%0d", want.line_number, got.line_number)};
    if (want.vsync_active !== got.vsync_active)
      d = {d, $sformatf(" vsync_active %0b/%0b", want.vsync_active, got.vsync_active)};
    if (want.irq_raise !== got.irq_raise)
      d = {d, $sformatf(" irq_raise %0b/%0b", want.irq_raise, got.irq_raise)};
    if (want.draw_valid !== got.draw_valid)
      d = {d, $sformatf(" draw_valid %0b/%0b", want.draw_valid, got.draw_valid)};
    if (want.draw_row !== got.draw_row)
      d = {d, $sformatf(" draw_row %0d/%0d", want.draw_row, got.draw_row)};
    if (want.border_line !== got.border_line)
      d = {d, $sformatf(" border_line %0b/%0b", want.border_line, got.border_line)};
    if (want.video_addr !== got.video_addr)
      d = {d, $sformatf(" video_addr %h/%h", want.video_addr, got.video_addr)};
    if (want.raster_addr !== got.raster_addr)
      d = {d, $sformatf(" raster_addr %h/%h", want.raster_addr, got.raster_addr)};
    if (want.resync_flag !== got.resync_flag)
      d = {d, $sformatf(" resync_flag %0b/%0b", want.resync_flag, got.resync_flag)};
    if (want.x_start !== got.x_start)
      d = {d, $sformatf(" x_start %0d/%0d", want.x_start, got.x_start)};
    if (want.x_end !== got.x_end)
      d = {d, $sformatf(" x_end %0d/%0d", want.x_end, got.x_end)};
    return d;
  endfunction

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t: mismatch:%s", $time, what);
  endfunction

  always @(posedge clk) begin
    crtclt_pkg::crtclt_out_t want;
    if (rst) begin
      reset_timing();
      due_status.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_status.size() == 0) begin
          note_failure(" result word with nothing expected");
        end else begin
          want = due_status.pop_front();
          if (out_data !== want)
            note_failure({" (expected/actual)", field_diffs(want, out_data)});
        end
      end
      if (in_valid && in_ready) due_status.push_back(apply_word(in_data));
    end
    outstanding <= due_status.size();
    mismatches <= fail_count;
  end

endmodule

[verif/crtc_line_timing_test.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the CRTC line timing block, with its scoreboard alongside.
module crtc_line_timing_test;

  localparam int WordTarget = 1050;
  localparam int TailCycles = 8;

  localparam int RegHTotal    = 0;
  localparam int RegHDisp     = 1;
  localparam int RegHSyncPos  = 2;
  localparam int RegVTotal    = 4;
  localparam int RegVDisp     = 6;
  localparam int RegVSyncPos  = 7;
  localparam int RegInterlace = 8;
  localparam int RegMaxRaster = 9;
  localparam int RegStartHi   = 12;
  localparam int RegStartLo   = 13;
  localparam int RegSelectTop = 31;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CADENCE, RX_CHOKE} rx_mode_e;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  crtclt_pkg::crtclt_in_t  in_data;
  logic                    out_valid;
  logic                    out_ready;
  crtclt_pkg::crtclt_out_t out_data;
  int          mismatches;
  int          outstanding;

  int          burst_left = 0;
  int          words_sent = 0;
  bit          steady = 1'b0;

  rx_mode_e    rx_mode;
  int          rx_left = 0;
  int          rx_phase = 0;

  crtc_line_timing u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  crtc_line_timing_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // The receiver switches between open, coin-flip, fixed-cadence and heavy stalling.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 200);
    end else begin
      rx_left--;
    end
    rx_phase++;
    case (rx_mode)
      RX_OPEN:    out_ready <= 1'b1;
      RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
      RX_CADENCE: out_ready <= (rx_phase % 3) != 0;
      default:    out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_word(input crtclt_pkg::crtclt_in_t w);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic bus_write(input logic [15:0] addr, input logic [7:0] data);
    crtclt_pkg::crtclt_in_t w;
    w.func = crtclt_pkg::FUNC_BUS_WRITE;
    w.bus_addr = addr;
    w.bus_data = data;
    send_word(w);
  endtask

  // Bits outside the decode mask and above the select field are don't-care, so they
  // are randomized on every register access.
  task automatic reg_write(input int idx, input logic [7:0] val);
    bus_write(crtclt_pkg::ADDR_SELECT | (16'($urandom) & ~crtclt_pkg::ADDR_DECODE_MASK),
              {3'($urandom), 5'(idx)});
    bus_write(crtclt_pkg::ADDR_DATA | (16'($urandom) & ~crtclt_pkg::ADDR_DECODE_MASK), val);
  endtask

  task automatic ticks(input int n);
    crtclt_pkg::crtclt_in_t w;
    repeat (n) begin
      w.func = crtclt_pkg::FUNC_TICK;
      w.bus_addr = 16'($urandom);
      w.bus_data = 8'($urandom);
      send_word(w);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int vtot;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    rst = 1'b1;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset state, decode corners, write masks and horizontal extremes.
    ticks(1);
    bus_write(16'h0000, 8'h00);
    bus_write(crtclt_pkg::ADDR_SELECT, 8'hFF);
    bus_write(crtclt_pkg::ADDR_DATA, 8'h5A);
    bus_write(16'hFC00, 8'(RegInterlace));
    bus_write(16'hFDFF, 8'hFF);
    reg_write(RegHSyncPos, 8'h00);
    reg_write(RegHDisp, 8'hFF);
    reg_write(RegMaxRaster, 8'h00);
    reg_write(RegVTotal, 8'h01);
    reg_write(RegVSyncPos, 8'h01);
    reg_write(RegVDisp, 8'h00);
    ticks(3);
    drain();

    while (words_sent < WordTarget) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          steady = ($urandom_range(0, 3) == 0);
          vtot = ($urandom_range(0, 7) == 0) ? 127 : $urandom_range(0, 40);
          if ($urandom_range(0, 3) != 0)
            reg_write(RegMaxRaster, ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                               : 8'($urandom_range(0, 7)));
          if ($urandom_range(0, 3) != 0) reg_write(RegVTotal, 8'(vtot));
          if ($urandom_range(0, 3) != 0)
            reg_write(RegVSyncPos, ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                              : 8'($urandom_range(0, vtot + 1)));
          if ($urandom_range(0, 3) != 0) reg_write(RegVDisp, 8'($urandom));
          if ($urandom_range(0, 3) != 0)
            reg_write(RegHDisp, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(20, 48)));
          if ($urandom_range(0, 3) != 0) reg_write(RegHSyncPos, 8'($urandom));
          if ($urandom_range(0, 2) == 0) reg_write(RegStartHi, 8'($urandom));
          if ($urandom_range(0, 2) == 0) reg_write(RegStartLo, 8'($urandom));
          reg_write($urandom_range(RegHTotal, 15), 8'($urandom));
          ticks($urandom_range(20, 160));
        end
        7, 8: begin
          repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 2))
              0: bus_write(16'($urandom), 8'($urandom));
              1: bus_write(crtclt_pkg::ADDR_SELECT
                           | (16'($urandom) & ~crtclt_pkg::ADDR_DECODE_MASK),
                           8'($urandom_range(0, RegSelectTop)));
              default: bus_write(crtclt_pkg::ADDR_DATA
                                 | (16'($urandom) & ~crtclt_pkg::ADDR_DECODE_MASK),
                                 8'($urandom));
            endcase
          end
        end
        default: drain();
      endcase
    end

    drain();
    repeat (TailCycles) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/crtclt_pkg.sv
rtl/crtclt_regs.sv
rtl/crtclt_timing.sv
rtl/crtc_line_timing.sv
verif/crtc_line_timing_checker.sv
verif/crtc_line_timing_test.sv
